[rtl/prsm_pkg.sv]
// ----------------------------------------------------------------------------
// Packet ring space manager package
// Shared widths, types and operation codes of the ring space manager.
// ----------------------------------------------------------------------------
package prsm_pkg;

  localparam int unsigned OP_W   = 3;
  localparam int unsigned LEN_W  = 12;
  localparam int unsigned ADDR_W = 16;
  localparam int unsigned CNT_W  = 17;

  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [CNT_W:0]   ext_t;
  typedef logic [LEN_W-1:0] len_t;

  // buffer size after reset
  localparam cnt_t BUFFER_BYTES_RESET = cnt_t'(65536);

  typedef enum logic [OP_W-1:0] {
    OP_RESERVE      = 3'd0,
    OP_READ_RELEASE = 3'd1,
    OP_PEEK_RELEASE = 3'd2,
    OP_PEEK         = 3'd3,
    OP_EMPTY        = 3'd4
  } opcode_e;

endpackage

[rtl/packet_ring_space_manager.sv]
// ----------------------------------------------------------------------------
// Packet ring space manager
// Tracks write offset, read offset and fill of a circular packet buffer.
// ----------------------------------------------------------------------------
// Usage:
//   The slave stream carries one operation per transfer: the opcode in
//   s_axis_tuser and the packet length in s_axis_tdata. Each operation
//   produces exactly one result on the master stream: the ok flag in
//   m_axis_tuser and the address, fill and free counts in m_axis_tdata.
//   The buffer size is written through cfg_we_i / cfg_wdata_i; the user
//   must do so only while no operation is in flight, which the block
//   does not enforce. A size of 0 acts as 1 and sizes above
//   BUFFER_BYTES_MAX are clamped. An accepted operation lands in the input
//   register; once the result register is free, it is computed against the
//   offset and fill registers and loads the result register. Throughput is
//   one operation per cycle while the receiver does not stall, set by the
//   single update of the three state registers.
//   Reset clears offsets, fill and both valid flags and sets the size to
//   65536. When the receiver stalls, the result register holds, the input
//   register fills, and then s_axis_tready drops until a transfer drains.
// ----------------------------------------------------------------------------
module packet_ring_space_manager #(
  parameter int unsigned MAX_PACKET       = 2048,
  parameter int unsigned BUFFER_BYTES_MAX = 65536
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [prsm_pkg::CNT_W-1:0]   cfg_wdata_i,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [15:0]                  s_axis_tdata,   // [11:0] length, [15:12] zero
  input  logic [prsm_pkg::OP_W-1:0]    s_axis_tuser,   // [2:0] opcode
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [55:0]                  m_axis_tdata,   // [15:0] address, [32:16] fill,
                                                       // [49:33] free_bytes, [55:50] zero
  output logic                         m_axis_tuser    // [0] ok
);

  localparam int unsigned CntW   = prsm_pkg::CNT_W;
  localparam int unsigned CntMax = (1 << CntW) - 1;
  localparam int unsigned SizeCapI =
      (BUFFER_BYTES_MAX > CntMax) ? CntMax : BUFFER_BYTES_MAX;
  localparam prsm_pkg::cnt_t SizeCap = prsm_pkg::cnt_t'(SizeCapI);
  localparam prsm_pkg::ext_t MaxPkt  = prsm_pkg::ext_t'(MAX_PACKET);

  // configuration and state
  prsm_pkg::cnt_t size_cfg_q;
  prsm_pkg::cnt_t wr_off_q, wr_off_d;
  prsm_pkg::cnt_t rd_off_q, rd_off_d;
  prsm_pkg::cnt_t fill_q,   fill_d;

  // input register
  logic              in_valid_q;
  prsm_pkg::opcode_e in_op_q;
  prsm_pkg::len_t    in_len_q;

  // result register
  logic                           out_valid_q;
  logic                           out_ok_q,   out_ok_d;
  logic [prsm_pkg::ADDR_W-1:0]    out_addr_q, out_addr_d;
  prsm_pkg::cnt_t                 out_fill_q;
  prsm_pkg::cnt_t                 out_free_q, out_free_d;

  logic           out_free_slot;
  logic           advance_en;
  prsm_pkg::cnt_t size_eff;
  prsm_pkg::cnt_t free_now;
  prsm_pkg::cnt_t wr_wrap;
  prsm_pkg::cnt_t rd_wrap;
  prsm_pkg::cnt_t addr_full;

  function automatic prsm_pkg::cnt_t wrap_off(prsm_pkg::cnt_t off, prsm_pkg::cnt_t size);
    prsm_pkg::ext_t toend;
    toend = (off >= size) ? '0 : {1'b0, size - off};
    return (toend < MaxPkt) ? '0 : off;
  endfunction

  function automatic prsm_pkg::cnt_t advance(prsm_pkg::cnt_t off, prsm_pkg::len_t len,
                                             prsm_pkg::cnt_t size);
    prsm_pkg::ext_t n;
    n = {1'b0, off} + prsm_pkg::ext_t'(len);
    return (n > {1'b0, size}) ? size : n[CntW-1:0];
  endfunction

  function automatic prsm_pkg::cnt_t fill_sub(prsm_pkg::cnt_t fill, prsm_pkg::len_t len);
    return (fill >= prsm_pkg::cnt_t'(len)) ? fill - prsm_pkg::cnt_t'(len) : '0;
  endfunction

  // handshake
  assign out_free_slot = !out_valid_q || m_axis_tready;
  assign advance_en    = in_valid_q && out_free_slot;
  assign s_axis_tready = !in_valid_q || out_free_slot;

  // effective size and current counts
  always_comb begin
    if (size_cfg_q == '0) begin
      size_eff = prsm_pkg::cnt_t'(1);
    end else if (size_cfg_q > SizeCap) begin
      size_eff = SizeCap;
    end else begin
      size_eff = size_cfg_q;
    end
  end

  assign free_now = (fill_q >= size_eff) ? '0 : size_eff - fill_q;
  assign wr_wrap  = wrap_off(wr_off_q, size_eff);
  assign rd_wrap  = wrap_off(rd_off_q, size_eff);

  always_comb begin
    wr_off_d  = wr_off_q;
    rd_off_d  = rd_off_q;
    fill_d    = fill_q;
    out_ok_d  = 1'b0;
    addr_full = '0;
    unique case (in_op_q)
      prsm_pkg::OP_RESERVE: begin
        if ({1'b0, free_now} >= MaxPkt) begin
          out_ok_d  = 1'b1;
          addr_full = wr_wrap;
          wr_off_d  = advance(wr_wrap, in_len_q, size_eff);
          fill_d    = advance(fill_q, in_len_q, size_eff);
        end
      end
      prsm_pkg::OP_READ_RELEASE: begin
        if (fill_q != '0) begin
          out_ok_d  = 1'b1;
          addr_full = rd_wrap;
          fill_d    = fill_sub(fill_q, in_len_q);
          rd_off_d  = advance(rd_wrap, in_len_q, size_eff);
        end
      end
      prsm_pkg::OP_PEEK_RELEASE: begin
        out_ok_d  = 1'b1;
        addr_full = rd_off_q;
        fill_d    = fill_sub(fill_q, in_len_q);
        rd_off_d  = advance(rd_off_q, in_len_q, size_eff);
      end
      prsm_pkg::OP_PEEK: begin
        if (fill_q >= prsm_pkg::cnt_t'(in_len_q)) begin
          out_ok_d  = 1'b1;
          addr_full = rd_wrap;
          rd_off_d  = rd_wrap;
        end
      end
      prsm_pkg::OP_EMPTY: begin
        out_ok_d = 1'b1;
        wr_off_d = '0;
        rd_off_d = '0;
        fill_d   = '0;
      end
      default: begin
        // undefined opcode: report failure, keep state
        out_ok_d = 1'b0;
      end
    endcase
    out_addr_d = addr_full[prsm_pkg::ADDR_W-1:0];
    out_free_d = (fill_d >= size_eff) ? '0 : size_eff - fill_d;
  end

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_cfg_q <= prsm_pkg::BUFFER_BYTES_RESET;
    end else if (cfg_we_i) begin
      size_cfg_q <= cfg_wdata_i;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      wr_off_q    <= '0;
      rd_off_q    <= '0;
      fill_q      <= '0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (out_free_slot) begin
        out_valid_q <= advance_en;
      end
      if (advance_en) begin
        wr_off_q <= wr_off_d;
        rd_off_q <= rd_off_d;
        fill_q   <= fill_d;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_op_q  <= prsm_pkg::opcode_e'(s_axis_tuser);
      in_len_q <= s_axis_tdata[prsm_pkg::LEN_W-1:0];
    end
    if (advance_en) begin
      out_ok_q   <= out_ok_d;
      out_addr_q <= out_addr_d;
      out_fill_q <= fill_d;
      out_free_q <= out_free_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_ok_q;
  assign m_axis_tdata  = {6'b0, out_free_q, out_fill_q, out_addr_q};

`ifndef NO_ASSERTIONS
  // a computed operation always lands in the result register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_en |=> out_valid_q)
    else $error("computed operation lost");

  // input stalls only when both registers are occupied
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (in_valid_q && out_valid_q && !m_axis_tready))
    else $error("input stalled without backpressure");

  // a failed operation reports address zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ok_q) |-> (out_addr_q == '0))
    else $error("failed operation with nonzero address");

  // empty clears offsets and fill
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance_en && (in_op_q == prsm_pkg::OP_EMPTY)) |=>
      (fill_q == '0 && wr_off_q == '0 && rd_off_q == '0))
    else $error("empty did not clear state");
`endif

endmodule

[bench/prsm_result_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Packet ring space manager result checker
// Watches the operation and result streams and the size register writes.
// Keeps its own copy of the offsets and the fill, predicts each result and
// compares it field by field with what the block returns.
// ----------------------------------------------------------------------------
module prsm_result_checker #(
  parameter int unsigned MAX_PACKET       = 2048,
  parameter int unsigned BUFFER_BYTES_MAX = 65536
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [prsm_pkg::CNT_W-1:0] cfg_wdata_i,
  input  logic                       op_valid_i,
  input  logic                       op_ready_i,
  input  logic [15:0]                op_data_i,    // [11:0] length, [15:12] zero
  input  logic [prsm_pkg::OP_W-1:0]  op_user_i,    // [2:0] opcode
  input  logic                       res_valid_i,
  input  logic                       res_ready_i,
  input  logic [55:0]                res_data_i,   // [15:0] address, [32:16] fill,
                                                   // [49:33] free_bytes, [55:50] zero
  input  logic                       res_user_i,   // [0] ok
  output int unsigned                errors_o,
  output int unsigned                outstanding_o
);

  typedef struct packed {
    logic                        ok;
    logic [prsm_pkg::ADDR_W-1:0] address;
    prsm_pkg::cnt_t              fill;
    prsm_pkg::cnt_t              free_bytes;
  } ring_result_t;

  ring_result_t ring_results_q[$];

  prsm_pkg::cnt_t size_reg = prsm_pkg::BUFFER_BYTES_RESET;
  prsm_pkg::cnt_t wr_off   = '0;
  prsm_pkg::cnt_t rd_off   = '0;
  prsm_pkg::cnt_t fill_cnt = '0;

  function automatic prsm_pkg::cnt_t clamp_size(prsm_pkg::cnt_t raw);
    if (raw == '0) return prsm_pkg::cnt_t'(1);
    if (raw > prsm_pkg::cnt_t'(BUFFER_BYTES_MAX)) return prsm_pkg::cnt_t'(BUFFER_BYTES_MAX);
    return raw;
  endfunction

  function automatic prsm_pkg::cnt_t space_left(prsm_pkg::cnt_t fill, prsm_pkg::cnt_t size);
    return (fill >= size) ? '0 : size - fill;
  endfunction

  // an offset too close to the end restarts at zero so a packet never splits
  function automatic prsm_pkg::cnt_t wrap_offset(prsm_pkg::cnt_t off, prsm_pkg::cnt_t size);
    prsm_pkg::cnt_t to_end;
    to_end = (off >= size) ? '0 : size - off;
    return (to_end < prsm_pkg::cnt_t'(MAX_PACKET)) ? '0 : off;
  endfunction

  function automatic prsm_pkg::cnt_t step_sat(prsm_pkg::cnt_t base, prsm_pkg::len_t len,
                                              prsm_pkg::cnt_t size);
    prsm_pkg::ext_t sum;
    sum = prsm_pkg::ext_t'(base) + prsm_pkg::ext_t'(len);
    return (sum > prsm_pkg::ext_t'(size)) ? size : prsm_pkg::cnt_t'(sum);
  endfunction

  function automatic prsm_pkg::cnt_t drain_fill(prsm_pkg::cnt_t fill, prsm_pkg::len_t len);
    return (fill >= prsm_pkg::cnt_t'(len)) ? fill - prsm_pkg::cnt_t'(len) : '0;
  endfunction

  function automatic ring_result_t apply_ring_op(logic [prsm_pkg::OP_W-1:0] op,
                                                 prsm_pkg::len_t len);
    prsm_pkg::cnt_t size;
    prsm_pkg::cnt_t at;
    logic           ok;
    ring_result_t   res;
    size = clamp_size(size_reg);
    at   = '0;
    ok   = 1'b0;
    case (op)
      prsm_pkg::OP_RESERVE: begin
        if (space_left(fill_cnt, size) >= prsm_pkg::cnt_t'(MAX_PACKET)) begin
          wr_off   = wrap_offset(wr_off, size);
          at       = wr_off;
          wr_off   = step_sat(wr_off, len, size);
          fill_cnt = step_sat(fill_cnt, len, size);
          ok       = 1'b1;
        end
      end
      prsm_pkg::OP_READ_RELEASE: begin
        if (fill_cnt != '0) begin
          rd_off   = wrap_offset(rd_off, size);
          at       = rd_off;
          fill_cnt = drain_fill(fill_cnt, len);
          rd_off   = step_sat(rd_off, len, size);
          ok       = 1'b1;
        end
      end
      prsm_pkg::OP_PEEK_RELEASE: begin
        at       = rd_off;
        fill_cnt = drain_fill(fill_cnt, len);
        rd_off   = step_sat(rd_off, len, size);
        ok       = 1'b1;
      end
      prsm_pkg::OP_PEEK: begin
        if (fill_cnt >= prsm_pkg::cnt_t'(len)) begin
          rd_off = wrap_offset(rd_off, size);
          at     = rd_off;
          ok     = 1'b1;
        end
      end
      prsm_pkg::OP_EMPTY: begin
        fill_cnt = '0;
        wr_off   = '0;
        rd_off   = '0;
        ok       = 1'b1;
      end
      default: ;
    endcase
    res.ok         = ok;
    res.address    = at[prsm_pkg::ADDR_W-1:0];
    res.fill       = fill_cnt;
    res.free_bytes = space_left(fill_cnt, size);
    return res;
  endfunction

  task automatic check_field(string name, int unsigned exp, int unsigned act);
    if (exp != act) begin
      errors_o++;
      $display("%0t ns: %s mismatch: expected %0d, actual %0d", $time, name, exp, act);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    ring_result_t want;
    ring_result_t got;
    if (!rst_ni) begin
      size_reg      = prsm_pkg::BUFFER_BYTES_RESET;
      wr_off        = '0;
      rd_off        = '0;
      fill_cnt      = '0;
      errors_o      = 0;
      outstanding_o = 0;
      ring_results_q.delete();
    end else begin
      if (cfg_we_i) size_reg = cfg_wdata_i;
      if (res_valid_i && res_ready_i) begin
        got = {res_user_i, res_data_i[15:0], res_data_i[32:16], res_data_i[49:33]};
        if (ring_results_q.size() == 0) begin
          errors_o++;
          $display({"%0t ns: unexpected result: expected none, ",
                    "actual ok %0d address %0d fill %0d free %0d"},
                   $time, got.ok, got.address, got.fill, got.free_bytes);
        end else begin
          want = ring_results_q.pop_front();
          check_field("ok", want.ok, got.ok);
          check_field("address", want.address, got.address);
          check_field("fill", want.fill, got.fill);
          check_field("free_bytes", want.free_bytes, got.free_bytes);
        end
      end
      if (op_valid_i && op_ready_i) begin
        ring_results_q.push_back(apply_ring_op(op_user_i,
            prsm_pkg::len_t'(op_data_i[prsm_pkg::LEN_W-1:0])));
      end
      outstanding_o = ring_results_q.size();
    end
  end

endmodule

[bench/packet_ring_space_manager_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Packet ring space manager testbench
// Drives directed and random ring operations through several buffer sizes,
// with random gaps on both streams and one long result stall. The checker
// predicts every result; this module only makes stimulus and the verdict.
// ----------------------------------------------------------------------------
module packet_ring_space_manager_tb;

  localparam int unsigned CYCLE_LIMIT     = 400000;
  localparam int unsigned PHASE_ITEMS     = 95;
  localparam int unsigned SHORT_ITEMS     = 40;
  localparam int unsigned HOLD_OFF_CYCLES = 150;
  localparam int unsigned GAP_MAX         = 17;

  typedef logic [prsm_pkg::OP_W-1:0] op_bits_t;

  logic                      clk_i;
  logic                      rst_ni;
  logic                      cfg_we;
  logic [prsm_pkg::CNT_W-1:0] cfg_wdata;
  logic                      s_tvalid;
  logic                      s_tready;
  logic [15:0]               s_tdata;
  op_bits_t                  s_tuser;
  logic                      m_tvalid;
  logic                      m_tready;
  logic [55:0]               m_tdata;
  logic                      m_tuser;

  int unsigned               errors;
  int unsigned               outstanding;
  int unsigned               cycle_cnt;
  bit                        tx_burst;
  bit                        rx_burst;
  bit                        hold_off_req;
  prsm_pkg::len_t            packet_lens[$];

  packet_ring_space_manager dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tuser  (s_tuser),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),
    .m_axis_tuser  (m_tuser)
  );

  prsm_result_checker result_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),
    .op_valid_i    (s_tvalid),
    .op_ready_i    (s_tready),
    .op_data_i     (s_tdata),
    .op_user_i     (s_tuser),
    .res_valid_i   (m_tvalid),
    .res_ready_i   (m_tready),
    .res_data_i    (m_tdata),
    .res_user_i    (m_tuser),
    .errors_o      (errors),
    .outstanding_o (outstanding)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("packet_ring_space_manager test failed");
    $finish;
  end

  // Called and returns at a falling edge; valid stays high into a zero gap.
  task automatic send_op(op_bits_t op, prsm_pkg::len_t len);
    int unsigned gap;
    gap = tx_burst ? 0 : $urandom_range(0, GAP_MAX);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {4'b0000, len};
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Hold the sender until every result is back, let the pipe drain, then write the size.
  task automatic write_size(prsm_pkg::cnt_t value);
    s_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk_i);
    repeat (3) @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  function automatic prsm_pkg::len_t draw_len();
    int unsigned pick;
    pick = $urandom_range(0, 15);
    if (pick == 0) return '0;
    if (pick == 1) return prsm_pkg::len_t'($urandom_range(2049, 4095));
    return prsm_pkg::len_t'($urandom_range(1, 2048));
  endfunction

  // Mostly matched write/read packet traffic, the rest random noise.
  task automatic run_phase(prsm_pkg::cnt_t size, int unsigned items, bit burst,
                           bit with_hold);
    int unsigned    sent;
    int unsigned    pick;
    bit             hold_armed;
    prsm_pkg::len_t len;
    op_bits_t       op;
    write_size(size);
    packet_lens.delete();
    tx_burst   = burst;
    hold_armed = with_hold;
    sent       = 0;
    while (sent < items) begin
      if (hold_armed && sent >= 20) begin
        hold_off_req = 1'b1;
        hold_armed   = 1'b0;
      end
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        len = draw_len();
        send_op(prsm_pkg::OP_RESERVE, len);
        packet_lens.push_back(len);
        sent++;
      end else if (pick < 85 && packet_lens.size() > 0) begin
        len = packet_lens.pop_front();
        if (pick < 65) begin
          send_op(prsm_pkg::OP_READ_RELEASE, len);
          sent++;
        end else begin
          send_op(prsm_pkg::OP_PEEK, len);
          send_op(prsm_pkg::OP_PEEK_RELEASE, len);
          sent += 2;
        end
      end else begin
        op  = op_bits_t'($urandom_range(0, 7));
        len = prsm_pkg::len_t'($urandom_range(0, 4095));
        if (op == prsm_pkg::OP_EMPTY) packet_lens.delete();
        send_op(op, len);
        sent++;
      end
    end
  endtask

  // Result side: random hold-offs, bursts of back-to-back transfers and
  // one long stall on request.
  initial begin : result_sink
    int unsigned gap;
    bit          hold_done;
    m_tready  = 1'b0;
    rx_burst  = 1'b0;
    hold_done = 1'b0;
    @(negedge clk_i);
    forever begin
      if ($urandom_range(0, 39) == 0) rx_burst = !rx_burst;
      gap = rx_burst ? 0 : $urandom_range(0, GAP_MAX);
      if (hold_off_req && !hold_done) begin
        hold_done = 1'b1;
        gap       = HOLD_OFF_CYCLES;
      end
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      m_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_tvalid) @(posedge clk_i);
      @(negedge clk_i);
    end
  end

  initial begin
    rst_ni       = 1'b0;
    cfg_we       = 1'b0;
    cfg_wdata    = '0;
    s_tvalid     = 1'b0;
    s_tdata      = '0;
    s_tuser      = '0;
    tx_burst     = 1'b0;
    hold_off_req = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset size, empty ring: failures, saturation at zero, undefined codes
    send_op(prsm_pkg::OP_PEEK, prsm_pkg::len_t'(0));
    send_op(prsm_pkg::OP_READ_RELEASE, prsm_pkg::len_t'(0));
    send_op(prsm_pkg::OP_PEEK, prsm_pkg::len_t'(1));
    send_op(prsm_pkg::OP_PEEK_RELEASE, prsm_pkg::len_t'(7));
    send_op(prsm_pkg::OP_RESERVE, prsm_pkg::len_t'(4095));
    send_op(prsm_pkg::OP_RESERVE, prsm_pkg::len_t'(2048));
    send_op(prsm_pkg::OP_RESERVE, prsm_pkg::len_t'(0));
    send_op(prsm_pkg::OP_PEEK, prsm_pkg::len_t'(4095));
    send_op(prsm_pkg::OP_READ_RELEASE, prsm_pkg::len_t'(4095));
    send_op(prsm_pkg::OP_PEEK, prsm_pkg::len_t'(2049));
    send_op(prsm_pkg::OP_PEEK_RELEASE, prsm_pkg::len_t'(2048));
    send_op(prsm_pkg::OP_READ_RELEASE, prsm_pkg::len_t'(1));
    send_op(3'd5, prsm_pkg::len_t'(4095));
    send_op(3'd6, prsm_pkg::len_t'(0));
    send_op(3'd7, prsm_pkg::len_t'(2048));
    send_op(prsm_pkg::OP_RESERVE, prsm_pkg::len_t'(1000));
    send_op(prsm_pkg::OP_EMPTY, prsm_pkg::len_t'(4095));
    send_op(prsm_pkg::OP_RESERVE, prsm_pkg::len_t'(2048));
    send_op(prsm_pkg::OP_EMPTY, prsm_pkg::len_t'(0));

    // shrink step by step so offsets and fill end up past the new end, then an over-large and random sizes
    run_phase(prsm_pkg::BUFFER_BYTES_RESET, PHASE_ITEMS, 1'b1, 1'b1);
    run_phase(prsm_pkg::cnt_t'(6000), PHASE_ITEMS, 1'b0, 1'b0);
    run_phase(prsm_pkg::cnt_t'(4096), PHASE_ITEMS, 1'b0, 1'b0);
    run_phase(prsm_pkg::cnt_t'(2048), PHASE_ITEMS, 1'b1, 1'b0);
    run_phase(prsm_pkg::cnt_t'(2047), PHASE_ITEMS, 1'b0, 1'b0);
    run_phase(prsm_pkg::cnt_t'(0), SHORT_ITEMS, 1'b0, 1'b0);
    run_phase(prsm_pkg::cnt_t'(1), SHORT_ITEMS, 1'b1, 1'b0);
    run_phase(prsm_pkg::cnt_t'(131071), PHASE_ITEMS, 1'b0, 1'b0);
    run_phase(prsm_pkg::cnt_t'($urandom_range(2048, 16384)), PHASE_ITEMS, 1'b0, 1'b0);
    run_phase(prsm_pkg::cnt_t'($urandom_range(0, 131071)), PHASE_ITEMS, 1'b1, 1'b0);

    s_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
    if (errors == 0) begin
      $display("packet_ring_space_manager test passed");
    end else begin
      $display("packet_ring_space_manager test failed");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/prsm_pkg.sv
rtl/packet_ring_space_manager.sv
bench/prsm_result_checker.sv
bench/packet_ring_space_manager_tb.sv
